### rtl/circular_double_ended_queue_unit_macros.svh
// ---------------------------------------------------------------------------
// circular double-ended queue assertion macros
// shared property forms for the queue's concurrent checks
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CDEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cdeq_pkg.sv
// ---------------------------------------------------------------------------
// cdeq_pkg
// field widths, operation and status codes, controller types for the deque
// ---------------------------------------------------------------------------
package cdeq_pkg;

	// payload field widths
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5,
		OP_REVERSE    = 3'd6
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture the incoming item
		logic exec;      // apply the item to pointers and storage
		logic out_load;  // move the finished result into the output register
	} cmd_t;

endpackage

### rtl/cdeq_req_if.sv
// ---------------------------------------------------------------------------
// cdeq_req_if
// request channel: operation, word and logical position with valid/ready
// ---------------------------------------------------------------------------
interface cdeq_req_if;
	logic                                valid;
	logic                                ready;
	logic [cdeq_pkg::OP_W-1:0]           op;
	logic signed [cdeq_pkg::VALUE_W-1:0] value;
	logic [cdeq_pkg::POS_W-1:0]          position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink   (input valid, input op, input value, input position, output ready);
endinterface

### rtl/cdeq_rsp_if.sv
// ---------------------------------------------------------------------------
// cdeq_rsp_if
// response channel: result word, status and element count with valid/ready
// ---------------------------------------------------------------------------
interface cdeq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [cdeq_pkg::VALUE_W-1:0] result_value;
	logic [cdeq_pkg::STATUS_W-1:0]       status;
	logic [cdeq_pkg::COUNT_W-1:0]        count;

	modport source (output valid, output result_value, output status, output count,
		input ready);
	modport sink   (input valid, input result_value, input status, input count,
		output ready);
endinterface

### rtl/cdeq_ctrl.sv
// ---------------------------------------------------------------------------
// cdeq_ctrl
// sequencer: accept one item, apply it, hand the result to the output register
// ---------------------------------------------------------------------------
module cdeq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output cdeq_pkg::cmd_t cmd
);
	import cdeq_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	// state register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// commands and handshake outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/cdeq_dpath.sv
// ---------------------------------------------------------------------------
// cdeq_dpath
// ring storage, end pointers, count, orientation and result registers
// ---------------------------------------------------------------------------
module cdeq_dpath #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdeq_pkg::cmd_t                      cmd,
	input  logic [cdeq_pkg::OP_W-1:0]           op,
	input  logic signed [cdeq_pkg::VALUE_W-1:0] value,
	input  logic [cdeq_pkg::POS_W-1:0]          position,
	output logic signed [cdeq_pkg::VALUE_W-1:0] result_value,
	output logic [cdeq_pkg::STATUS_W-1:0]       status,
	output logic [cdeq_pkg::COUNT_W-1:0]        count
);
	import cdeq_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// item captured at accept
	logic [OP_W-1:0]       op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [POS_W-1:0]      pos_q;

	// queue state
	logic [AW-1:0]         front_q, back_q;
	logic [CW-1:0]         cnt_q;
	logic                  rev_q;

	// execution results
	status_t               st_q;
	logic                  has_rd_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// output register
	logic [VALUE_W-1:0]    res_q;
	logic [STATUS_W-1:0]   status_q;
	logic [COUNT_W-1:0]    count_q;

	// combinational execution signals
	logic                  full, empty, in_range;
	logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec;
	logic [CMPW-1:0]       pos_ext, cnt_ext, lpos;
	logic [AW:0]           slot_sum;
	logic [AW-1:0]         slot;
	logic [AW-1:0]         mem_addr;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         front_nxt, back_nxt;
	logic [CW-1:0]         cnt_nxt;
	logic                  rev_nxt;
	status_t               st_nxt;

	// capture the item; word kept to the storage width
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			val_q <= DATA_WIDTH'($unsigned(value));
			pos_q <= position;
		end
	end

	// occupancy checks and wrapping pointer steps
	always_comb begin
		full      = (cnt_q == CW'(DEPTH));
		empty     = (cnt_q == '0);
		pos_ext   = CMPW'(pos_q);
		cnt_ext   = CMPW'(cnt_q);
		in_range  = (pos_ext < cnt_ext);
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
		back_inc  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);
		back_dec  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);
	end

	// physical slot of a logical position, mirrored when reversed
	always_comb begin
		lpos     = rev_q ? (cnt_ext - CMPW'(1) - pos_ext) : pos_ext;
		slot_sum = {1'b0, front_q} + {1'b0, lpos[AW-1:0]};
		slot     = (slot_sum >= (AW + 1)'(DEPTH)) ?
			AW'(slot_sum - (AW + 1)'(DEPTH)) : slot_sum[AW-1:0];
	end

	// operation decode: storage access and next queue state
	always_comb begin
		mem_addr  = slot;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		front_nxt = front_q;
		back_nxt  = back_q;
		cnt_nxt   = cnt_q;
		rev_nxt   = rev_q;
		st_nxt    = ST_OK;
		case (op_q)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					st_nxt = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					cnt_nxt = cnt_q + CW'(1);
					if ((op_q == OP_PUSH_BACK) != rev_q) begin
						mem_addr = back_q;
						back_nxt = back_inc;
					end else begin
						mem_addr  = front_dec;
						front_nxt = front_dec;
					end
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					mem_re  = 1'b1;
					cnt_nxt = cnt_q - CW'(1);
					if ((op_q == OP_POP_BACK) != rev_q) begin
						mem_addr = back_dec;
						back_nxt = back_dec;
					end else begin
						mem_addr  = front_q;
						front_nxt = front_inc;
					end
				end
			end
			OP_READ: begin
				if (in_range) mem_re = 1'b1;
				else          st_nxt = ST_RANGE;
			end
			OP_WRITE: begin
				if (in_range) mem_we = 1'b1;
				else          st_nxt = ST_RANGE;
			end
			OP_REVERSE: begin
				rev_nxt = !rev_q;
			end
			default: begin
				st_nxt = ST_OK;
			end
		endcase
	end

	// queue state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.exec) begin
			front_q <= front_nxt;
			back_q  <= back_nxt;
			cnt_q   <= cnt_nxt;
			rev_q   <= rev_nxt;
		end
	end

	// execution status for the result stage
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q     <= st_nxt;
			has_rd_q <= mem_re;
		end
	end

	// ring storage, one access per item, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) mem_q[mem_addr] <= val_q;
		if (cmd.exec && mem_re) rd_q <= mem_q[mem_addr];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q    <= has_rd_q ? VALUE_W'(rd_q) : '0;
			status_q <= st_q;
			count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign result_value = res_q;
	assign status       = status_q;
	assign count        = count_q;

endmodule

### rtl/circular_double_ended_queue_unit.sv
// A result becomes valid once its item is accepted, executed and then moved into
// the output register; the hand-off waits while an earlier result is untaken.
// A new item is taken only while the sequencer is idle, after the last one is handed off.
// A waiting result holds in the output register while the next item runs.
// Reset (arst_n low) empties the queue and restores normal orientation at once;
// storage contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// circular_double_ended_queue_unit
// fixed-capacity ring-buffer deque with push, pop, indexed access and reverse
// ---------------------------------------------------------------------------
`include "circular_double_ended_queue_unit_macros.svh"

module circular_double_ended_queue_unit #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	cdeq_req_if.sink   req,
	cdeq_rsp_if.source rsp
);
	import cdeq_pkg::*;

	cmd_t cmd;

	// sequencer
	cdeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// storage and queue state
	cdeq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (req.op),
		.value        (req.value),
		.position     (req.position),
		.result_value (rsp.result_value),
		.status       (rsp.status),
		.count        (rsp.count)
	);

	// checks
	`CDEQ_ASSERT_NOW(a_full_count, clk, arst_n, rsp.valid && (rsp.status == ST_FULL), rsp.count == COUNT_W'(DEPTH), "full reject with count below capacity")
	`CDEQ_ASSERT_NOW(a_empty_count, clk, arst_n, rsp.valid && (rsp.status == ST_EMPTY), rsp.count == '0, "empty reject with nonzero count")
	`CDEQ_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, !(rsp.valid && !rsp.ready), "result overwritten before it was taken")
	`CDEQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req.valid && req.ready, !req.ready && cmd.exec, "accepted item not executed next cycle")

endmodule

### tb/sv/cdeq_tb_pkg.sv
// ---------------------------------------------------------------------------
// cdeq_tb_pkg
// deque predictor and result scoreboard for the circular deque testbench;
// keeps its own copy of the ring, pointers, count and orientation
// ---------------------------------------------------------------------------
package cdeq_tb_pkg;
	import cdeq_pkg::*;

	localparam int              DEQUE_DEPTH = 1024;
	// op code outside the defined set, must leave the queue untouched
	localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

	// one expected result item
	typedef struct packed {
		logic signed [VALUE_W-1:0] word;
		status_t                   status;
		logic [COUNT_W-1:0]        count;
	} deque_result_t;

	class deque_scoreboard;
		logic [VALUE_W-1:0] slots [DEQUE_DEPTH];
		logic [POS_W-1:0]   front_slot;
		logic [POS_W-1:0]   back_slot;
		logic [COUNT_W-1:0] elements;
		bit                 mirrored;
		deque_result_t      expected_results [$];
		int                 errors;

		function new();
			front_slot = '0;
			back_slot  = '0;
			elements   = '0;
			mirrored   = 1'b0;
			errors     = 0;
		endfunction

		task report_mismatch(string msg);
			$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		// apply one request to the shadow deque, return its result
		function deque_result_t apply_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
			logic [POS_W-1:0] position);
			deque_result_t      res;
			logic [COUNT_W-1:0] offset;
			logic [POS_W-1:0]   slot;
			bit                 at_back;
			res.word   = '0;
			res.status = ST_OK;
			case (op)
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (elements >= DEQUE_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						// reversed orientation swaps the physical ends
						at_back = (op == OP_PUSH_BACK) != mirrored;
						if (at_back) begin
							slots[back_slot] = value;
							back_slot++;
						end else begin
							front_slot--;
							slots[front_slot] = value;
						end
						elements++;
					end
				end
				OP_POP_BACK, OP_POP_FRONT: begin
					if (elements == 0) begin
						res.status = ST_EMPTY;
					end else begin
						at_back = (op == OP_POP_BACK) != mirrored;
						if (at_back) begin
							back_slot--;
							res.word = slots[back_slot];
						end else begin
							res.word = slots[front_slot];
							front_slot++;
						end
						elements--;
					end
				end
				OP_READ, OP_WRITE: begin
					if ({1'b0, position} >= elements) begin
						res.status = ST_RANGE;
					end else begin
						// mirrored positions count from the physical back
						offset = mirrored ? elements - 11'd1 - {1'b0, position} : {1'b0, position};
						slot   = front_slot + offset[POS_W-1:0];
						if (op == OP_READ)
							res.word = slots[slot];
						else
							slots[slot] = value;
					end
				end
				OP_REVERSE: begin
					mirrored = !mirrored;
				end
				default: begin
				end
			endcase
			res.count = elements;
			return res;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
			logic [POS_W-1:0] position);
			expected_results = {expected_results, apply_request(op, value, position)};
		endfunction

		// compare one accepted result item with the oldest expectation
		task check_response(logic [VALUE_W-1:0] word, logic [STATUS_W-1:0] status,
			logic [COUNT_W-1:0] count);
			deque_result_t exp;
			if (expected_results.size() == 0) begin
				report_mismatch("result item with nothing expected");
			end else begin
				exp = expected_results[0];
				expected_results.delete(0);
				if (exp.word !== word)
					report_mismatch($sformatf("result_value %h, expected %h", word, exp.word));
				if (exp.status !== status)
					report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
				if (exp.count !== count)
					report_mismatch($sformatf("count %0d, expected %0d", count, exp.count));
			end
		endtask
	endclass

endpackage

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// drives push, pop, indexed access and reverse requests into the deque and
// checks every result item against a shadow deque, with random idling on
// both channels, a long result stall and a fill past capacity
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdeq_pkg::*;
	import cdeq_tb_pkg::*;

	logic clk;
	logic arst_n;
	bit   steady;

	cdeq_req_if req_ch ();
	cdeq_rsp_if rsp_ch ();

	deque_scoreboard board;

	circular_double_ended_queue_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// offer one item, return at the edge that accepts it
	task send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
		logic [POS_W-1:0] position);
		bit taken;
		if (!steady && $urandom_range(99) < 32) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value    <= value;
		req_ch.position <= position;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		board.note_request(op, value, position);
	endtask

	// random item with push and pop weights in percent
	task random_request(int push_pct, int pop_pct);
		int               pick;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] position;
		pick = $urandom_range(99);
		if (pick < push_pct)
			op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else if (pick < push_pct + pop_pct)
			op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		else if (pick < 97)
			op = $urandom_range(1) ? OP_READ : OP_WRITE;
		else
			op = OP_REVERSE;
		// mostly in range, sometimes anywhere
		if (board.elements != 0 && $urandom_range(9) < 8)
			position = POS_W'($urandom_range(board.elements - 1));
		else
			position = POS_W'($urandom_range(DEQUE_DEPTH - 1));
		send_request(op, $urandom(), position);
	endtask

	// wait until every expected result item has come
	task drain_results();
		while (board.expected_results.size() != 0) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off, checking
	initial begin
		bit                 fire;
		bit                 held;
		int                 hold_left;
		int                 responses;
		logic [VALUE_W-1:0] word;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0] count;
		held      = 1'b0;
		hold_left = 0;
		responses = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			fire   = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);
			word   = rsp_ch.result_value;
			status = rsp_ch.status;
			count  = rsp_ch.count;
			@(posedge clk);
			if (fire) begin
				board.check_response(word, status, count);
				responses++;
			end
			if (responses == 120 && !held) begin
				held      = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (!steady && $urandom_range(99) < 32) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// request side
	initial begin
		int full_hits;
		int fill_items;
		board  = new();
		steady = 1'b0;
		arst_n = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_PUSH_BACK;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue rejects
		send_request(OP_POP_BACK, 32'h0, 10'd0);
		send_request(OP_POP_FRONT, 32'hffff_ffff, 10'd0);
		send_request(OP_READ, 32'h0, 10'd0);
		send_request(OP_WRITE, 32'h1234_5678, 10'd1023);
		// reverse on an empty queue
		send_request(OP_REVERSE, 32'h0, 10'd0);
		send_request(OP_REVERSE, 32'h0, 10'd0);
		// word extremes at both ends
		send_request(OP_PUSH_BACK, 32'h7fff_ffff, 10'd0);
		send_request(OP_PUSH_FRONT, 32'h8000_0000, 10'd0);
		send_request(OP_PUSH_BACK, 32'h0000_0000, 10'd1023);
		send_request(OP_PUSH_FRONT, 32'hffff_ffff, 10'd0);
		send_request(OP_READ, 32'h0, 10'd0);
		send_request(OP_READ, 32'h0, 10'd3);
		send_request(OP_READ, 32'h0, 10'd4);
		send_request(OP_WRITE, 32'h5555_aaaa, 10'd2);
		// mirrored view
		send_request(OP_REVERSE, 32'h0, 10'd0);
		send_request(OP_READ, 32'h0, 10'd0);
		send_request(OP_READ, 32'h0, 10'd1);
		send_request(OP_PUSH_BACK, 32'haaaa_5555, 10'd0);
		send_request(OP_POP_FRONT, 32'h0, 10'd0);
		send_request(OP_POP_BACK, 32'h0, 10'd0);
		// unused op code leaves everything alone
		send_request(OP_UNUSED, 32'hffff_ffff, 10'd1023);
		send_request(OP_REVERSE, 32'h0, 10'd0);
		send_request(OP_READ, 32'h0, 10'd1);
		send_request(OP_POP_FRONT, 32'h0, 10'd0);

		// mixed traffic around a small count
		repeat (12) random_request(35, 35);

		// sender pause until everything is back
		req_ch.valid <= 1'b0;
		drain_results();

		// fill to capacity and push against a full queue, long result stall falls here
		full_hits  = 0;
		fill_items = 0;
		while (full_hits < 8) begin
			steady = (fill_items >= 150 && fill_items < 450);
			if (board.elements == DEQUE_DEPTH) begin
				full_hits++;
				if (full_hits == 1) begin
					send_request(OP_READ, 32'h0, 10'd1023);
					send_request(OP_WRITE, $urandom(), 10'd1023);
					send_request(OP_READ, 32'h0, 10'd1023);
				end
			end
			random_request(98, 0);
			fill_items++;
		end
		steady = 1'b0;

		// partial drain
		repeat (12) random_request(10, 70);

		req_ch.valid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("PASS circular_double_ended_queue_unit");
		else
			$display("FAIL circular_double_ended_queue_unit");
		$finish;
	end

	// timeout
	initial begin
		#5_000_000;
		$display("FAIL circular_double_ended_queue_unit");
		$finish;
	end

endmodule
